@@ sv/fas_pkg.sv @@
// Shared types, codes and widths of the frame animation sequencer.
package fas_pkg;

  // Field and register widths fixed by the command and result formats.
  localparam int OPCODE_W    = 4;
  localparam int NOW_W       = 32;
  localparam int TARGET_W    = 10;
  localparam int INDEX_W     = 8;
  localparam int CFG_COUNT_W = 9;
  localparam int CFG_TIME_W  = 31;
  localparam int CFG_MODE_W  = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  // Defaults for the top-level parameters.
  localparam int MAX_FRAMES_DEF = 256;
  localparam int TIME_BITS_DEF  = 32;

  // Register reset values.
  localparam logic [CFG_COUNT_W-1:0] FRAME_COUNT_RST    = CFG_COUNT_W'(1);
  localparam logic [CFG_TIME_W-1:0]  FRAME_INTERVAL_RST = CFG_TIME_W'(100);

  typedef enum logic [OPCODE_W-1:0] {
    OP_REFRESH       = 4'd0,
    OP_ARM           = 4'd1,
    OP_START         = 4'd2,
    OP_PAUSE         = 4'd3,
    OP_RESUME        = 4'd4,
    OP_RESTART       = 4'd5,
    OP_STOP          = 4'd6,
    OP_STOP_AT       = 4'd7,
    OP_DISARM        = 4'd8,
    OP_BLINK_RESTART = 4'd9
  } op_e;

  typedef enum logic [CFG_MODE_W-1:0] {
    MODE_LOOP     = 2'd0,
    MODE_ONCE     = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_REVERSE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_PLAYING = 2'd1,
    ST_PAUSED  = 2'd2
  } play_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT    = 2'd0,
    CFG_FRAME_INTERVAL = 2'd1,
    CFG_ANIM_MODE      = 2'd2,
    CFG_BLINK_PERIOD   = 2'd3
  } cfg_e;

endpackage

@@ sv/fas_channels.sv @@
// Request channels of the frame animation sequencer: command in, result out.
interface fas_cmd_if;
  import fas_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [NOW_W-1:0]           now;
  logic signed [TARGET_W-1:0] target_frame;

  modport source (output valid, opcode, now, target_frame, input ready);
  modport sink   (input valid, opcode, now, target_frame, output ready);
endinterface

interface fas_res_if;
  import fas_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] frame_index;
  logic               frame_chosen;
  logic               static_image;
  logic               blink_visible;
  logic               playing;
  logic               frame_advanced;

  modport source (output valid, frame_index, frame_chosen, static_image, blink_visible,
                  playing, frame_advanced, input ready);
  modport sink   (input valid, frame_index, frame_chosen, static_image, blink_visible,
                  playing, frame_advanced, output ready);
endinterface

@@ sv/frame_animation_sequencer_top.sv @@
// Sprite frame sequencer with blink phase: command register, state update, result register.
//
//   channel   dir  handshake          payload
//   cmd_i     in   valid / ready      opcode, now, target_frame
//   res_o     out  valid / ready      frame_index, frame_chosen, static_image,
//                                     blink_visible, playing, frame_advanced
//   cfg       in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// Each command passes through the command register and then the result register;
// one command is taken every cycle while results are taken.
// The sequence state is updated in the cycle a command moves from the command register
// to the result register; one subtract-and-compare per timestamp sets the path length.
// Reset (asynchronous, active low) empties both registers, clears the sequence state and
// restores the register defaults.
// A stalled result holds the result register and, behind it, the command register.
module frame_animation_sequencer_top #(
  parameter int MAX_FRAMES = fas_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = fas_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fas_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fas_cmd_if.sink                        cmd_i,
  fas_res_if.source                      res_o
);
  import fas_pkg::*;

  localparam int FRAME_BITS = $clog2(MAX_FRAMES);
  localparam int CNT_BITS   = (FRAME_BITS + 1 > CFG_COUNT_W) ? FRAME_BITS + 1 : CFG_COUNT_W;
  localparam int CMP_BITS   = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W + 1;

  localparam logic [CNT_BITS-1:0] N_MAX = CNT_BITS'(MAX_FRAMES);
  localparam logic [CNT_BITS-1:0] N_ONE = CNT_BITS'(1);

  // Configuration registers.
  logic [CFG_COUNT_W-1:0] frame_count_q;
  logic [CFG_TIME_W-1:0]  frame_interval_q;
  logic [CFG_MODE_W-1:0]  anim_mode_q;
  logic [CFG_TIME_W-1:0]  blink_period_q;

  // Command register.
  logic                       cmd_vld_q;
  logic [OPCODE_W-1:0]        op_q;
  logic [NOW_W-1:0]           now_q;
  logic signed [TARGET_W-1:0] tgt_q;

  // Sequence state.
  logic                  armed_q, armed_d;
  play_e                 play_q, play_d;
  logic                  down_q, down_d;
  logic [FRAME_BITS-1:0] cur_q, cur_d;
  logic                  chosen_q, chosen_d;
  logic [TIME_BITS-1:0]  last_adv_q, last_adv_d;
  logic [TIME_BITS-1:0]  blink_mark_q, blink_mark_d;
  logic                  phase_q, phase_d;
  logic                  adv;

  // Result register.
  logic               res_vld_q;
  logic [INDEX_W-1:0] res_index_q;
  logic               res_chosen_q;
  logic               res_static_q;
  logic               res_visible_q;
  logic               res_playing_q;
  logic               res_adv_q;

  logic step;

  // A command moves on when the result register is free or being emptied.
  assign step        = cmd_vld_q && (!res_vld_q || res_o.ready);
  assign cmd_i.ready = !cmd_vld_q || step;

  // Effective frame count: zero reads as one, saturated at the frame store size.
  logic [CNT_BITS-1:0]   fc_x, n, n_m1, cur_x, cur_inc, cur_dec;
  logic [FRAME_BITS-1:0] last_frame;

  always_comb begin
    fc_x = CNT_BITS'(frame_count_q);
    if (fc_x == '0) begin
      fc_x = N_ONE;
    end
    n          = (fc_x > N_MAX) ? N_MAX : fc_x;
    n_m1       = n - N_ONE;
    last_frame = FRAME_BITS'(n_m1);
    cur_x      = CNT_BITS'(cur_q);
    cur_inc    = cur_x + N_ONE;
    cur_dec    = cur_x - N_ONE;
  end

  // Wrapped time differences against the blink mark and the last advance.
  logic [TIME_BITS-1:0] now_t, bdiff, bmag, fdiff;
  logic                 blink_due, frame_due;

  always_comb begin
    now_t     = TIME_BITS'(now_q);
    bdiff     = now_t - blink_mark_q;
    bmag      = bdiff[TIME_BITS-1] ? (~bdiff + 1'b1) : bdiff;
    blink_due = CMP_BITS'(bmag) >= CMP_BITS'(blink_period_q);
    fdiff     = now_t - last_adv_q;
    frame_due = !fdiff[TIME_BITS-1] && (CMP_BITS'(fdiff) >= CMP_BITS'(frame_interval_q));
  end

  // One advance step under the current mode.
  logic [FRAME_BITS-1:0] adv_frame;
  logic                  adv_down;
  logic                  adv_stop;

  always_comb begin
    adv_frame = cur_q;
    adv_down  = down_q;
    adv_stop  = 1'b0;
    unique case (mode_e'(anim_mode_q))
      MODE_LOOP: begin
        adv_frame = (cur_inc >= n) ? '0 : FRAME_BITS'(cur_inc);
      end
      MODE_ONCE: begin
        if (cur_inc < n) begin
          adv_frame = FRAME_BITS'(cur_inc);
        end else begin
          adv_stop = 1'b1;
        end
      end
      MODE_PINGPONG: begin
        if (down_q) begin
          // Stepping down: from frame zero the candidate falls below zero.
          if (cur_x != '0 && cur_dec >= n_m1) begin
            adv_frame = last_frame;
            adv_down  = 1'b1;
          end else if (cur_x == '0 || cur_dec == '0) begin
            adv_frame = '0;
            adv_down  = 1'b0;
          end else begin
            adv_frame = FRAME_BITS'(cur_dec);
          end
        end else begin
          if (cur_inc >= n_m1) begin
            adv_frame = last_frame;
            adv_down  = 1'b1;
          end else begin
            adv_frame = FRAME_BITS'(cur_inc);
          end
        end
      end
      MODE_REVERSE: begin
        adv_frame = (cur_x == '0) ? last_frame : FRAME_BITS'(cur_dec);
      end
    endcase
  end

  // Start frame and clamped stop target.
  logic [FRAME_BITS-1:0] start_frame, stop_frame, clamp_frame;
  logic                  reverse;
  logic [CNT_BITS-1:0]   tgt_x;

  always_comb begin
    reverse     = mode_e'(anim_mode_q) == MODE_REVERSE;
    start_frame = reverse ? last_frame : '0;
    clamp_frame = (cur_x >= n) ? last_frame : cur_q;
    tgt_x       = tgt_q[TARGET_W-1] ? '0 : CNT_BITS'(tgt_q[TARGET_W-2:0]);
    stop_frame  = (tgt_x >= n) ? last_frame : FRAME_BITS'(tgt_x);
  end

  // Next sequence state for the command in the command register.
  always_comb begin
    armed_d      = armed_q;
    play_d       = play_q;
    down_d       = down_q;
    cur_d        = cur_q;
    chosen_d     = chosen_q;
    last_adv_d   = last_adv_q;
    blink_mark_d = blink_mark_q;
    phase_d      = phase_q;
    adv          = 1'b0;
    unique case (op_e'(op_q))
      OP_REFRESH: begin
        if (blink_period_q != '0) begin
          if (blink_due) begin
            blink_mark_d = now_t;
            phase_d      = !phase_q;
          end
        end else begin
          phase_d = 1'b1;
        end
        if (phase_d && armed_q && play_q == ST_PLAYING && frame_due) begin
          last_adv_d = now_t;
          cur_d      = adv_frame;
          down_d     = adv_down;
          if (adv_stop) begin
            play_d = ST_STOPPED;
          end
          chosen_d = 1'b1;
          adv      = 1'b1;
        end
      end
      OP_ARM: begin
        armed_d    = 1'b1;
        cur_d      = start_frame;
        down_d     = reverse;
        chosen_d   = 1'b0;
        play_d     = ST_PLAYING;
        last_adv_d = now_t;
      end
      OP_START: begin
        if (armed_q) begin
          play_d     = ST_PLAYING;
          last_adv_d = now_t;
          down_d     = reverse;
        end
      end
      OP_PAUSE: begin
        if (play_q == ST_PLAYING) begin
          play_d = ST_PAUSED;
        end
      end
      OP_RESUME: begin
        if (play_q == ST_PAUSED) begin
          play_d     = ST_PLAYING;
          last_adv_d = now_t;
        end
      end
      OP_RESTART: begin
        if (armed_q) begin
          cur_d      = start_frame;
          down_d     = reverse;
          play_d     = ST_PLAYING;
          last_adv_d = now_t;
        end
      end
      OP_STOP: begin
        if (armed_q) begin
          play_d   = ST_STOPPED;
          cur_d    = clamp_frame;
          chosen_d = 1'b1;
        end
      end
      OP_STOP_AT: begin
        if (armed_q) begin
          cur_d    = stop_frame;
          play_d   = ST_STOPPED;
          chosen_d = 1'b1;
        end
      end
      OP_DISARM: begin
        armed_d  = 1'b0;
        chosen_d = 1'b0;
        play_d   = ST_STOPPED;
      end
      OP_BLINK_RESTART: begin
        blink_mark_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q    <= FRAME_COUNT_RST;
      frame_interval_q <= FRAME_INTERVAL_RST;
      anim_mode_q      <= MODE_LOOP;
      blink_period_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_FRAME_COUNT:    frame_count_q    <= cfg_data_i[CFG_COUNT_W-1:0];
        CFG_FRAME_INTERVAL: frame_interval_q <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_ANIM_MODE:      anim_mode_q      <= cfg_data_i[CFG_MODE_W-1:0];
        CFG_BLINK_PERIOD:   blink_period_q   <= cfg_data_i[CFG_TIME_W-1:0];
      endcase
    end
  end

  // Command register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_vld_q <= cmd_i.valid;
    end
  end

  // Command register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      op_q  <= cmd_i.opcode;
      now_q <= cmd_i.now;
      tgt_q <= cmd_i.target_frame;
    end
  end

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= 1'b0;
      play_q       <= ST_STOPPED;
      down_q       <= 1'b0;
      cur_q        <= '0;
      chosen_q     <= 1'b0;
      last_adv_q   <= '0;
      blink_mark_q <= '0;
      phase_q      <= 1'b1;
    end else if (step) begin
      armed_q      <= armed_d;
      play_q       <= play_d;
      down_q       <= down_d;
      cur_q        <= cur_d;
      chosen_q     <= chosen_d;
      last_adv_q   <= last_adv_d;
      blink_mark_q <= blink_mark_d;
      phase_q      <= phase_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (step) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result register payload, taken from the state after the command.
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_index_q   <= INDEX_W'(cur_d);
      res_chosen_q  <= chosen_d;
      res_static_q  <= !armed_d;
      res_visible_q <= phase_d;
      res_playing_q <= armed_d && (play_d == ST_PLAYING);
      res_adv_q     <= adv;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.frame_index    = res_index_q;
  assign res_o.frame_chosen   = res_chosen_q;
  assign res_o.static_image   = res_static_q;
  assign res_o.blink_visible  = res_visible_q;
  assign res_o.playing        = res_playing_q;
  assign res_o.frame_advanced = res_adv_q;

  // A running or paused sequence is always armed.
  a_play_needs_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_q != ST_STOPPED |-> armed_q)
    else $error("sequence active while disarmed");

  // An advance always marks a frame as chosen.
  a_adv_chosen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_adv_q |-> res_chosen_q)
    else $error("frame advanced without being chosen");

  // A playing result can never report the base image.
  a_play_static: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_playing_q |-> !res_static_q)
    else $error("playing while static image shown");

  // A held command is not lost while the result side stalls.
  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_q && !step |=> cmd_vld_q && $stable(op_q) && $stable(now_q))
    else $error("stalled command dropped");

endmodule
